/* src/md5_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 shared definitions
// Round constants, rotation amounts, initial chaining values and the command
// and status bundles between the MD5 controller and datapath.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam logic [31:0] INIT_WORDS [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic take_byte;
      logic load_work;
      logic do_round;
      logic fold;
      logic pad_word;
      logic zero_word;
      logic sweep_clear;
      logic out_next;
      logic out_done;
   } cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pad_word_last;
      logic len_fits;
      logic round_last;
      logic sweep_last;
      logic out_last;
   } sts_type;

endpackage

/* src/md5_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer with byte lanes, bit counter, chaining and working words, the
// round unit (one round per cycle) and the digest output selection.
// ----------------------------------------------------------------------------
module md5_dpath (
   input  logic               clock,
   input  logic               reset,
   input  md5_pkg::cmd_type   cmd,
   output md5_pkg::sts_type   sts,
   input  logic [7:0]         req_data_byte,
   output logic [31:0]        rsp_digest_word,
   output logic [1:0]         rsp_word_number,
   output logic               rsp_final_word
);

   logic [3:0][7:0] blk_ff [16];
   logic [31:0]     chain_ff [4];
   logic [31:0]     work_ff [4];
   logic [63:0]     cnt_ff;
   logic [5:0]      round_ff;
   logic [3:0]      sweep_ff;
   logic            len_ff;
   logic [1:0]      out_ff;

   logic            wr_en;
   logic [3:0]      wr_addr;
   logic [3:0]      wr_be;
   logic [3:0][7:0] wr_data;

   logic [31:0] f_val;
   logic [3:0]  g_idx;
   logic [31:0] sum;
   logic [63:0] rot_tmp;
   logic [31:0] new_b;
   logic [4:0]  rot;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[8:5];
      wr_be   = 4'b0000;
      wr_data = '0;
      if (cmd.take_byte) begin
         wr_en   = 1'b1;
         wr_be   = 4'b0001 << cnt_ff[4:3];
         wr_data = {4{req_data_byte}};
      end else if (cmd.pad_word) begin
         wr_en = 1'b1;
         for (int j = 0; j < 4; j++) begin
            wr_be[j]   = (2'(j) >= cnt_ff[4:3]);
            wr_data[j] = (2'(j) == cnt_ff[4:3]) ? md5_pkg::PAD_BYTE : 8'h00;
         end
      end else if (cmd.zero_word) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_be   = 4'b1111;
         if (len_ff && sweep_ff == 4'd14) begin
            wr_data = cnt_ff[31:0];
         end else if (len_ff && sweep_ff == 4'd15) begin
            wr_data = cnt_ff[63:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int j = 0; j < 4; j++) begin
            if (wr_be[j]) begin
               blk_ff[wr_addr][j] <= wr_data[j];
            end
         end
      end
   end

   always_comb begin
      case (round_ff[5:4])
         2'd0: begin
            f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
            g_idx = round_ff[3:0];
         end
         2'd1: begin
            f_val = (work_ff[3] & work_ff[1]) | (~work_ff[3] & work_ff[2]);
            g_idx = 4'((round_ff[3:0] << 2) + round_ff[3:0] + 4'd1);
         end
         2'd2: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            g_idx = 4'((round_ff[3:0] << 1) + round_ff[3:0] + 4'd5);
         end
         default: begin
            f_val = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
            g_idx = 4'((round_ff[3:0] << 3) - round_ff[3:0]);
         end
      endcase
      rot     = md5_pkg::ROT_AMOUNT[{round_ff[5:4], round_ff[1:0]}];
      sum     = f_val + work_ff[0] + md5_pkg::ROUND_CONST[round_ff] + blk_ff[g_idx];
      rot_tmp = {sum, sum} << rot;
      new_b   = work_ff[1] + rot_tmp[63:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         work_ff <= chain_ff;
      end else if (cmd.do_round) begin
         work_ff[0] <= work_ff[3];
         work_ff[1] <= new_b;
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= md5_pkg::INIT_WORDS;
         cnt_ff   <= '0;
         round_ff <= '0;
         sweep_ff <= '0;
         len_ff   <= 1'b0;
         out_ff   <= '0;
      end else begin
         if (cmd.take_byte) begin
            cnt_ff <= cnt_ff + 64'd8;
         end
         if (cmd.load_work) begin
            round_ff <= '0;
         end else if (cmd.do_round) begin
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.fold) begin
            for (int w = 0; w < 4; w++) begin
               chain_ff[w] <= chain_ff[w] + work_ff[w];
            end
         end
         if (cmd.pad_word) begin
            sweep_ff <= cnt_ff[8:5] + 4'd1;
            len_ff   <= sts.len_fits;
         end else if (cmd.sweep_clear) begin
            sweep_ff <= '0;
            len_ff   <= 1'b1;
         end else if (cmd.zero_word) begin
            sweep_ff <= sweep_ff + 4'd1;
         end
         if (cmd.out_next) begin
            out_ff <= out_ff + 2'd1;
         end
         if (cmd.out_done) begin
            chain_ff <= md5_pkg::INIT_WORDS;
            cnt_ff   <= '0;
         end
      end
   end

   always_comb begin
      sts.pos_last      = (cnt_ff[8:3] == 6'd63);
      sts.pad_word_last = (cnt_ff[8:5] == 4'd15);
      sts.len_fits      = (cnt_ff[8:6] != 3'b111);
      sts.round_last    = (round_ff == 6'd63);
      sts.sweep_last    = (sweep_ff == 4'd15);
      sts.out_last      = (out_ff == 2'd3);
   end

   assign rsp_digest_word = chain_ff[out_ff];
   assign rsp_word_number = out_ff;
   assign rsp_final_word  = (out_ff == 2'd3);

endmodule

/* src/md5_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte intake, block compression, padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_byte_present,
   input  logic               req_end_of_message,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output md5_pkg::cmd_type   cmd,
   input  md5_pkg::sts_type   sts
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_ZERO, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_DATA, MODE_PAD_FIRST, MODE_FINAL
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      last_pending_ff, last_pending_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      last_pending_in = last_pending_ff;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.take_byte = req_byte_present;
               if (req_byte_present && sts.pos_last) begin
                  state_in        = ST_LOAD;
                  mode_in         = MODE_DATA;
                  last_pending_in = req_end_of_message;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (sts.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            case (mode_ff)
               MODE_DATA: begin
                  state_in = last_pending_ff ? ST_PAD : ST_IDLE;
               end
               MODE_PAD_FIRST: begin
                  cmd.sweep_clear = 1'b1;
                  mode_in         = MODE_FINAL;
                  state_in        = ST_ZERO;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_PAD: begin
            cmd.pad_word    = 1'b1;
            last_pending_in = 1'b0;
            mode_in         = sts.len_fits ? MODE_FINAL : MODE_PAD_FIRST;
            state_in        = sts.pad_word_last ? ST_LOAD : ST_ZERO;
         end
         ST_ZERO: begin
            cmd.zero_word = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               cmd.out_next = 1'b1;
               if (sts.out_last) begin
                  cmd.out_done = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_ff         <= MODE_DATA;
         last_pending_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         last_pending_ff <= last_pending_in;
      end
   end

   a_no_intake_during_output: assert property (@(posedge clock)
      rsp_valid |-> req_stall)
      else $error("Input taken while a digest word is pending.");

   a_reset_to_idle: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE))
      else $error("Controller not idle after reset.");

   a_rounds_then_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && sts.round_last) |=> (state_ff == ST_FOLD))
      else $error("Last round not followed by the chaining update.");

   a_full_block_stalls: assert property (@(posedge clock) disable iff (reset)
      (accept && req_byte_present && sts.pos_last) |=> req_stall)
      else $error("Full block did not start compression.");

   a_digest_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && sts.out_last) |=> !rsp_valid)
      else $error("Digest output ran past word D.");

endmodule

/* src/md5_message_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message digest
// Streams message bytes, pads the message at its end marker and returns the
// four chaining words of the digest.
//
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  data byte, byte present, end mark
// rsp_      out        rsp_valid/rsp_stall  digest word, word number, final
//
// A byte is taken every cycle while req_stall is low; the last byte of a 64-byte
// block holds the input for the load, 64 rounds and the chaining update.
// An end marker adds a pad word, up to 15 fill words and a compression, or up to
// 17 fill words and two compressions when the length needs a second block; the
// 4 digest words follow.
// Reset is synchronous. While rsp_stall is high the digest word and input hold.
// ----------------------------------------------------------------------------
module md5_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_number,
   output logic        rsp_final_word
);

   md5_pkg::cmd_type cmd;
   md5_pkg::sts_type sts;

   md5_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .sts                (sts)
   );

   md5_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_data_byte   (req_data_byte),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_number (rsp_word_number),
      .rsp_final_word  (rsp_final_word)
   );

endmodule
